>>> hdl/hsc_pkg.sv
`timescale 1ns / 1ps
package hsc_pkg;

  localparam int WordW        = 63;
  localparam int CountW       = 6;
  localparam int ActionW      = 2;
  localparam int BytesW       = 3;
  localparam int CfgIndexW    = 2;
  localparam int CfgDataW     = 6;
  localparam int MaxDataBits  = 56;
  localparam int ParityBits   = 6;
  localparam int MaxCodeBitsDefault = 63;

  localparam logic [BytesW-1:0] DataBytesReset    = 3'd1;
  localparam logic [CountW-1:0] CodewordBitsReset = 6'd12;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DATA_BYTES    = 2'd0,
    CFG_CODEWORD_BITS = 2'd1
  } cfg_index_t;

  typedef enum logic [ActionW-1:0] {
    ACT_ENCODE = 2'd0,
    ACT_DECODE = 2'd1,
    ACT_FIX    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_CLEAN  = 2'd0,
    STAT_DATA   = 2'd1,
    STAT_PARITY = 2'd2,
    STAT_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [WordW-1:0]  code;
    logic [CountW-1:0] count;
  } enc_result_t;

  typedef struct packed {
    logic [WordW-1:0]  data;
    logic [CountW-1:0] count;
    logic [CountW-1:0] syn;
    status_t           status;
    logic              fixed;
  } dec_result_t;

  function automatic logic is_pow2(int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // One-based codeword position that carries data bit d.
  function automatic int data_pos(int d);
    int seen;
    int found;
    seen  = 0;
    found = 0;
    for (int p = 1; p < 128; p++) begin
      if (!is_pow2(p)) begin
        if (seen == d && found == 0) begin
          found = p;
        end
        seen++;
      end
    end
    return found;
  endfunction

  // Codeword length produced by encode for a given byte count and length limit.
  function automatic int enc_count(int db, int lim);
    int nb;
    int pos;
    int d;
    nb  = db * 8;
    pos = 0;
    d   = 0;
    for (int i = 0; i < 64; i++) begin
      if (d < nb && pos < lim) begin
        if (!is_pow2(pos + 1)) begin
          d++;
        end
        pos++;
      end
    end
    return pos;
  endfunction

endpackage

>>> hdl/hsc_encoder.sv
`timescale 1ns / 1ps
module hsc_encoder #(
  parameter int MaxCodeBits = hsc_pkg::MaxCodeBitsDefault
) (
  input  logic [hsc_pkg::WordW-1:0]  word,
  input  logic [hsc_pkg::BytesW-1:0] data_bytes,
  output hsc_pkg::enc_result_t       res
);

  localparam int Lim = (MaxCodeBits < hsc_pkg::WordW) ? MaxCodeBits : hsc_pkg::WordW;

  logic [hsc_pkg::CountW-1:0] nbits;
  logic [hsc_pkg::CountW-1:0] cnt_tab [8];
  logic [hsc_pkg::CountW-1:0] cnt;
  logic [hsc_pkg::CountW-1:0] syn;
  logic [hsc_pkg::WordW-1:0]  code;

  assign nbits = {data_bytes, 3'b000};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cnt_tab[i] = hsc_pkg::CountW'(hsc_pkg::enc_count(i, Lim));
    end
  end

  assign cnt = cnt_tab[data_bytes];

  always_comb begin
    int pd;
    logic used;
    code = '0;
    syn  = '0;
    for (int d = 0; d < hsc_pkg::MaxDataBits; d++) begin
      pd   = hsc_pkg::data_pos(d);
      used = (pd <= Lim) && (hsc_pkg::CountW'(d) < nbits) && word[d];
      if (pd <= Lim) begin
        code[(pd <= hsc_pkg::WordW) ? pd - 1 : 0] = used;
      end
      if (used) begin
        syn = syn ^ hsc_pkg::CountW'(pd);
      end
    end
    // Parity bits only exist below the last used position.
    for (int k = 0; k < hsc_pkg::ParityBits; k++) begin
      if (hsc_pkg::CountW'(1 << k) < cnt) begin
        code[(1 << k) - 1] = syn[k];
      end
    end
  end

  assign res.code  = code;
  assign res.count = cnt;

endmodule

>>> hdl/hsc_decoder.sv
`timescale 1ns / 1ps
module hsc_decoder #(
  parameter int MaxCodeBits = hsc_pkg::MaxCodeBitsDefault
) (
  input  logic [hsc_pkg::WordW-1:0]  word,
  input  logic [hsc_pkg::CountW-1:0] codeword_bits,
  input  logic                       fix_en,
  output hsc_pkg::dec_result_t       res
);

  localparam int Lim = (MaxCodeBits < hsc_pkg::WordW) ? MaxCodeBits : hsc_pkg::WordW;

  logic [hsc_pkg::CountW-1:0] n;
  logic [hsc_pkg::CountW-1:0] syn;
  logic [hsc_pkg::CountW-1:0] cnt;
  logic [2:0]                 npar;
  logic [hsc_pkg::WordW-1:0]  data;
  logic [hsc_pkg::WordW-1:0]  flip;
  hsc_pkg::status_t           stat;
  logic                       do_fix;

  assign n = (codeword_bits > hsc_pkg::CountW'(Lim)) ? hsc_pkg::CountW'(Lim) : codeword_bits;

  always_comb begin
    syn = '0;
    for (int p = 0; p < hsc_pkg::WordW; p++) begin
      if (word[p] && (hsc_pkg::CountW'(p) < n)) begin
        syn = syn ^ hsc_pkg::CountW'(p + 1);
      end
    end
  end

  always_comb begin
    npar = '0;
    for (int k = 0; k < hsc_pkg::ParityBits; k++) begin
      if (hsc_pkg::CountW'(1 << k) <= n) begin
        npar = npar + 3'd1;
      end
    end
  end

  assign cnt = n - hsc_pkg::CountW'(npar);

  always_comb begin
    if (syn == '0) begin
      stat = hsc_pkg::STAT_CLEAN;
    end else if (syn > n) begin
      stat = hsc_pkg::STAT_RANGE;
    end else if ((syn & (syn - 1'b1)) == '0) begin
      stat = hsc_pkg::STAT_PARITY;
    end else begin
      stat = hsc_pkg::STAT_DATA;
    end
  end

  assign do_fix = fix_en && (stat == hsc_pkg::STAT_DATA);

  // A data-bit syndrome names a position inside the codeword, so the
  // flipped bit is always one that was extracted.
  always_comb begin
    int pd;
    int src;
    data = '0;
    flip = '0;
    for (int d = 0; d < hsc_pkg::WordW; d++) begin
      pd  = hsc_pkg::data_pos(d);
      src = (pd <= hsc_pkg::WordW) ? pd - 1 : 0;
      if (pd <= Lim) begin
        data[d] = word[src] && (hsc_pkg::CountW'(pd) <= n);
        flip[d] = do_fix && (syn == hsc_pkg::CountW'(pd));
      end
    end
  end

  assign res.data   = data ^ flip;
  assign res.count  = cnt;
  assign res.syn    = syn;
  assign res.status = stat;
  assign res.fixed  = do_fix;

endmodule

>>> hdl/hamming_sec_codec_top.sv
`timescale 1ns / 1ps
// A result passes from the input register through encode or decode into the result register.
// Throughput: one beat per cycle while out_stall is low; encode and decode are each a single
// combinational pass between the input register and the result register.
// Reset clears both valid flags and loads data_bytes = 1, codeword_bits = 12.
module hamming_sec_codec_top #(
  parameter int MaxCodeBits = hsc_pkg::MaxCodeBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hsc_pkg::ActionW-1:0]   action,
  input  logic [hsc_pkg::WordW-1:0]     word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsc_pkg::WordW-1:0]     result_word,
  output logic [hsc_pkg::CountW-1:0]    bit_count,
  output logic [hsc_pkg::CountW-1:0]    syndrome,
  output logic [1:0]                    status,
  output logic                          corrected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [hsc_pkg::CfgDataW-1:0]  cfg_data
);

  logic [hsc_pkg::BytesW-1:0]  data_bytes;
  logic [hsc_pkg::CountW-1:0]  codeword_bits;

  logic                        s1_valid;
  logic [hsc_pkg::ActionW-1:0] s1_action;
  logic [hsc_pkg::WordW-1:0]   s1_word;

  hsc_pkg::enc_result_t        enc_res;
  hsc_pkg::dec_result_t        dec_res;
  hsc_pkg::dec_result_t        out_res;
  hsc_pkg::dec_result_t        out_res_next;

  logic                        out_move;
  logic                        in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bytes    <= hsc_pkg::DataBytesReset;
      codeword_bits <= hsc_pkg::CodewordBitsReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hsc_pkg::CFG_DATA_BYTES:    data_bytes    <= cfg_data[hsc_pkg::BytesW-1:0];
        hsc_pkg::CFG_CODEWORD_BITS: codeword_bits <= cfg_data[hsc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // The result register frees up whenever it is empty or being taken.
  assign out_move = !(out_valid && out_stall);
  assign in_stall = s1_valid && !out_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (out_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= action;
      s1_word   <= word;
    end
  end

  hsc_encoder #(
    .MaxCodeBits(MaxCodeBits)
  ) u_enc (
    .word       (s1_word),
    .data_bytes (data_bytes),
    .res        (enc_res)
  );

  hsc_decoder #(
    .MaxCodeBits(MaxCodeBits)
  ) u_dec (
    .word          (s1_word),
    .codeword_bits (codeword_bits),
    .fix_en        (s1_action == hsc_pkg::ACT_FIX),
    .res           (dec_res)
  );

  always_comb begin
    if (s1_action == hsc_pkg::ACT_ENCODE) begin
      out_res_next.data   = enc_res.code;
      out_res_next.count  = enc_res.count;
      out_res_next.syn    = '0;
      out_res_next.status = hsc_pkg::STAT_CLEAN;
      out_res_next.fixed  = 1'b0;
    end else begin
      out_res_next = dec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s1_valid) begin
      out_res <= out_res_next;
    end
  end

  assign result_word = out_res.data;
  assign bit_count   = out_res.count;
  assign syndrome    = out_res.syn;
  assign status      = out_res.status;
  assign corrected   = out_res.fixed;

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register was free");

  a_fix_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && corrected) |-> (status == hsc_pkg::STAT_DATA))
    else $error("correction reported without a data bit error");

  a_clean_syndrome: assert property (@(posedge clk) disable iff (rst)
    (out_valid && syndrome == '0) |-> (status == hsc_pkg::STAT_CLEAN))
    else $error("zero syndrome with nonclean status");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the result register");

endmodule
